// ===== rtl/sync_len_xor_frame_parser_top_defines.svh =====
// Assertion helpers for the RTL (used by slxfp_back).
`ifndef SYNC_LEN_XOR_FRAME_PARSER_TOP_DEFINES_SVH
`define SYNC_LEN_XOR_FRAME_PARSER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define SLXFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define SLXFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/slxfp_pkg.sv =====
package slxfp_pkg;

  localparam logic [7:0] ALT_SYNC    = 8'hA5;
  localparam logic [7:0] SYNC_RESET  = 8'hA4;
  localparam logic       REG_SYNC    = 1'b0;
  localparam int         QDEPTH      = 2;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] len;
  } frame_desc_t;

  typedef enum logic [4:0] {
    F_HUNT = 5'b00001,
    F_LEN  = 5'b00010,
    F_ID   = 5'b00100,
    F_DATA = 5'b01000,
    F_CHK  = 5'b10000
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_SHOW = 3'b100
  } back_state_t;

endpackage

// ===== rtl/slxfp_front.sv =====
module slxfp_front #(
  parameter int MAX_DATA = 16,
  parameter int LW       = 5,
  parameter int AW       = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            sync_value,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            rx_byte,
  input  logic                  q_full,
  input  logic                  q_wslot,
  output logic                  push,
  output slxfp_pkg::frame_desc_t push_desc,
  output logic                  wr_en,
  output logic [AW:0]           wr_addr,
  output logic [7:0]            wr_data
);
  import slxfp_pkg::*;

  front_state_t  st;
  logic [7:0]    xacc;
  logic [LW-1:0] len;
  logic [7:0]    id;
  logic [LW-1:0] fill;
  logic          acc;
  logic [LW:0]   fill_inc;

  // the slot being filled is the queue's free entry, so hold off while full
  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign fill_inc = {1'b0, fill} + 1'b1;

  assign push         = acc && (st == F_CHK) && (rx_byte == xacc);
  assign push_desc.id  = id;
  assign push_desc.len = 8'(len);

  assign wr_en   = acc && (st == F_DATA);
  assign wr_addr = {q_wslot, fill[AW-1:0]};
  assign wr_data = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= F_HUNT;
      xacc <= '0;
      len  <= '0;
      fill <= '0;
      id   <= '0;
    end else if (acc) begin
      unique case (st)
        F_HUNT: begin
          if (rx_byte == sync_value || rx_byte == ALT_SYNC) begin
            xacc <= rx_byte;
            st   <= F_LEN;
          end
        end
        F_LEN: begin
          if (rx_byte > 8'(MAX_DATA)) begin
            st <= F_HUNT;
          end else begin
            len  <= LW'(rx_byte);
            xacc <= xacc ^ rx_byte;
            fill <= '0;
            st   <= F_ID;
          end
        end
        F_ID: begin
          id   <= rx_byte;
          xacc <= xacc ^ rx_byte;
          st   <= (len == '0) ? F_CHK : F_DATA;
        end
        F_DATA: begin
          fill <= fill_inc[LW-1:0];
          xacc <= xacc ^ rx_byte;
          if (fill_inc >= {1'b0, len}) begin
            st <= F_CHK;
          end
        end
        F_CHK: begin
          // a failing checksum byte equal to the primary sync reopens a frame
          if (rx_byte != xacc && rx_byte == sync_value) begin
            xacc <= rx_byte;
            st   <= F_LEN;
          end else begin
            st <= F_HUNT;
          end
        end
        default: begin
          st <= F_HUNT;
        end
      endcase
    end
  end

endmodule

// ===== rtl/slxfp_queue.sv =====
module slxfp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  slxfp_pkg::frame_desc_t push_desc,
  input  logic                   pop,
  output logic                   q_valid,
  output logic                   q_full,
  output slxfp_pkg::frame_desc_t head,
  output logic                   wslot,
  output logic                   rslot
);
  import slxfp_pkg::*;

  frame_desc_t ent [QDEPTH];
  logic        wptr;
  logic        rptr;
  logic [1:0]  cnt;

  assign q_valid = (cnt != 2'd0);
  assign q_full  = (cnt == 2'(QDEPTH));
  assign head    = ent[rptr];
  assign wslot   = wptr;
  assign rslot   = rptr;

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== rtl/slxfp_back.sv =====
`include "sync_len_xor_frame_parser_top_defines.svh"

module slxfp_back #(
  parameter int MAX_DATA = 16,
  parameter int LW       = 5,
  parameter int AW       = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [AW:0]            wr_addr,
  input  logic [7:0]             wr_data,
  input  logic                   q_valid,
  input  slxfp_pkg::frame_desc_t head,
  input  logic                   rslot,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             message_id,
  output logic [4:0]             data_count,
  output logic [3:0]             data_index,
  output logic [7:0]             data_value,
  output logic                   last_of_frame
);
  import slxfp_pkg::*;

  localparam int DEPTH = 2 ** (AW + 1);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_q;
  back_state_t   st;
  logic [LW-1:0] k;
  logic [LW-1:0] hlen;
  logic [LW-1:0] runlen;
  logic [LW:0]   k_inc;
  logic          last;
  logic          out_acc;

  // two frame slots; the parser fills one while this side drains the other
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (st == B_READ) begin
      rd_q <= mem[{rslot, k[AW-1:0]}];
    end
  end

  assign hlen    = LW'(head.len);
  assign runlen  = (hlen == '0) ? LW'(1) : hlen;
  assign k_inc   = {1'b0, k} + 1'b1;
  assign last    = (k_inc == {1'b0, runlen});

  assign out_valid = (st == B_SHOW);
  assign out_acc   = out_valid && !out_stall;
  assign pop       = out_acc && last;

  assign message_id    = head.id;
  assign data_count    = 5'(hlen);
  assign data_index    = 4'(k);
  assign data_value    = (hlen == '0) ? 8'd0 : rd_q;
  assign last_of_frame = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= B_IDLE;
      k  <= '0;
    end else begin
      unique case (st)
        B_IDLE: begin
          if (q_valid) begin
            k  <= '0;
            st <= B_READ;
          end
        end
        B_READ: begin
          st <= B_SHOW;
        end
        B_SHOW: begin
          if (out_acc) begin
            if (last) begin
              st <= B_IDLE;
            end else begin
              k  <= k_inc[LW-1:0];
              st <= B_READ;
            end
          end
        end
        default: begin
          st <= B_IDLE;
        end
      endcase
    end
  end

  `SLXFP_ASSERT_SAME(a_show_has_frame, st == B_SHOW, q_valid, "result shown with no queued frame")
  `SLXFP_ASSERT_NEXT(a_read_then_show, st == B_READ, st == B_SHOW, "read not followed by show")
  `SLXFP_ASSERT_NEXT(a_last_frees, pop, st == B_IDLE, "drain did not end after last result")

endmodule

// ===== rtl/sync_len_xor_frame_parser_top.sv =====
// Serial frame parser with XOR checksum.
// Input channel (in_valid / in_stall / rx_byte): one received byte per
// transaction. Frames are SYNC, LEN, ID, DATA[LEN], CHK, where SYNC is the
// sync_value register or 0xA5 and CHK is the XOR of all earlier bytes.
// Output channel (out_valid / out_stall): one transaction per data byte of a
// frame whose checksum matched, or one with data_value 0 for an empty frame;
// last_of_frame marks the final one.
// Throughput: the parser takes one byte per cycle. Up to two good frames sit
// in the descriptor queue and the double-buffered payload memory; with both
// slots full, in_stall is raised until the drain frees one.
// Each result of a frame comes from a registered memory read (B_READ) and
// is then presented (B_SHOW); the drain starts once the frame is queued and
// reads the next result only after the previous one was taken.
// A stalled output holds its fields; the drain waits, the parser keeps going
// until the queue fills.
// Reset (rst, synchronous) returns the parser to sync hunt, empties the queue
// and sets sync_value to 0xA4. No clearing pass is needed.
// Config: APB, register 0 (sync_value) at byte address 0; pready always high.
module sync_len_xor_frame_parser_top #(
  parameter int MAX_DATA = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  message_id,
  output logic [4:0]  data_count,
  output logic [3:0]  data_index,
  output logic [7:0]  data_value,
  output logic        last_of_frame
);
  import slxfp_pkg::*;

  localparam int LW = $clog2(MAX_DATA + 1);
  localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

  logic [7:0]  sync_value;
  logic        q_full;
  logic        q_valid;
  logic        wslot;
  logic        rslot;
  logic        push;
  logic        pop;
  frame_desc_t push_desc;
  frame_desc_t head;
  logic        wr_en;
  logic [AW:0] wr_addr;
  logic [7:0]  wr_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SYNC) ? {24'd0, sync_value} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= SYNC_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SYNC) begin
      sync_value <= pwdata[7:0];
    end
  end

  slxfp_front #(
    .MAX_DATA (MAX_DATA),
    .LW       (LW),
    .AW       (AW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .sync_value (sync_value),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .q_full     (q_full),
    .q_wslot    (wslot),
    .push       (push),
    .push_desc  (push_desc),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  slxfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .head      (head),
    .wslot     (wslot),
    .rslot     (rslot)
  );

  slxfp_back #(
    .MAX_DATA (MAX_DATA),
    .LW       (LW),
    .AW       (AW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .q_valid       (q_valid),
    .head          (head),
    .rslot         (rslot),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .message_id    (message_id),
    .data_count    (data_count),
    .data_index    (data_index),
    .data_value    (data_value),
    .last_of_frame (last_of_frame)
  );

endmodule
